// ----- rtl/core/pls_pkg.sv -----
// Shared types and codes for the positional list store.
package pls_pkg;

   localparam int unsigned ACT_W   = 3;
   localparam int unsigned VALUE_W = 32;
   localparam int unsigned POS_W   = 16;
   localparam int unsigned LEN_W   = 9;

   typedef enum logic [ACT_W-1:0] {
      ACT_INS_FRONT = 3'd0,
      ACT_INS_BACK  = 3'd1,
      ACT_REMOVE    = 3'd2,
      ACT_READ      = 3'd3,
      ACT_CLEAR     = 3'd4
   } action_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SHIFT,
      ST_DRAIN,
      ST_FRONT,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      CNT_HOLD,
      CNT_INC,
      CNT_DEC,
      CNT_CLR
   } cnt_op_type;

   typedef enum logic [1:0] {
      WR_NONE,
      WR_FRONT,
      WR_BACK
   } wr_kind_type;

   // controller to datapath
   typedef struct packed {
      logic        load_req;
      logic        ptr_load;
      logic        step;
      logic        rd_pos;
      wr_kind_type wr_kind;
      cnt_op_type  cnt_op;
      logic        out_load;
      logic        out_err;
      logic        out_rd;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      action_type act;
      logic       full;
      logic       empty;
      logic       pos_ok;
      logic       pos_at_end;
      logic       ptr_last;
   } stat_type;

endpackage

// ----- rtl/core/pls_ctrl.sv -----
// Sequencing state machine for the positional list store.
module pls_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  pls_pkg::stat_type stat,
   output pls_pkg::cmd_type  cmd
);
   import pls_pkg::*;

   state_type state_ff, state_in;
   logic      err_ff, err_in;
   logic      rdf_ff, rdf_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = ST_DONE;
            case (stat.act)
               ACT_INS_FRONT: begin
                  if (!stat.full) state_in = stat.empty ? ST_FRONT : ST_SHIFT;
               end
               ACT_REMOVE: begin
                  if (stat.pos_ok && !stat.pos_at_end) state_in = ST_SHIFT;
               end
               default: state_in = ST_DONE;
            endcase
         end
         ST_SHIFT: begin
            if (stat.ptr_last) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            state_in = (stat.act == ACT_INS_FRONT) ? ST_FRONT : ST_DONE;
         end
         ST_FRONT: state_in = ST_DONE;
         ST_DONE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd          = '0;
      cmd.wr_kind  = WR_NONE;
      cmd.cnt_op   = CNT_HOLD;
      cmd.out_err  = err_ff;
      cmd.out_rd   = rdf_ff;
      err_in       = err_ff;
      rdf_in       = rdf_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.load_req = req_tvalid;
         end
         ST_EXEC: begin
            err_in = 1'b1;
            rdf_in = 1'b0;
            case (stat.act)
               ACT_INS_FRONT: begin
                  err_in = stat.full;
                  if (!stat.full && !stat.empty) cmd.ptr_load = 1'b1;
               end
               ACT_INS_BACK: begin
                  err_in = stat.full;
                  if (!stat.full) begin
                     cmd.wr_kind = WR_BACK;
                     cmd.cnt_op  = CNT_INC;
                  end
               end
               ACT_REMOVE: begin
                  err_in = !stat.pos_ok;
                  if (stat.pos_ok) begin
                     if (stat.pos_at_end) cmd.cnt_op = CNT_DEC;
                     else cmd.ptr_load = 1'b1;
                  end
               end
               ACT_READ: begin
                  err_in     = !stat.pos_ok;
                  rdf_in     = stat.pos_ok;
                  cmd.rd_pos = stat.pos_ok;
               end
               ACT_CLEAR: begin
                  err_in     = 1'b0;
                  cmd.cnt_op = CNT_CLR;
               end
               default: err_in = 1'b1;
            endcase
         end
         ST_SHIFT: cmd.step = 1'b1;
         ST_DRAIN: begin
            if (stat.act != ACT_INS_FRONT) cmd.cnt_op = CNT_DEC;
         end
         ST_FRONT: begin
            cmd.wr_kind = WR_FRONT;
            cmd.cnt_op  = CNT_INC;
         end
         ST_DONE: begin
            cmd.out_load = out_free;
            if (out_free) rsp_valid_in = 1'b1;
         end
         default: cmd.load_req = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         err_ff       <= 1'b0;
         rdf_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         err_ff       <= err_in;
         rdf_ff       <= rdf_in;
      end
   end

endmodule

// ----- rtl/core/pls_datapath.sv -----
// Entry memory, count, walk pointer and result register of the list store.
module pls_datapath #(
   parameter int unsigned CAPACITY = 256
) (
   input  logic                          clock,
   input  logic                          reset,
   input  pls_pkg::cmd_type              cmd,
   output pls_pkg::stat_type             stat,
   input  logic [pls_pkg::ACT_W-1:0]     req_action,
   input  logic [pls_pkg::VALUE_W-1:0]   req_value,
   input  logic [pls_pkg::POS_W-1:0]     req_position,
   output logic                          rsp_status,
   output logic [pls_pkg::VALUE_W-1:0]   rsp_read_value,
   output logic [pls_pkg::LEN_W-1:0]     rsp_length
);
   import pls_pkg::*;

   localparam int unsigned AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int unsigned CW   = $clog2(CAPACITY + 1);
   localparam int unsigned CMPW = (CW > POS_W) ? CW : POS_W;

   logic [VALUE_W-1:0] mem [CAPACITY];

   action_type         act_ff;
   logic [VALUE_W-1:0] value_ff;
   logic [POS_W-1:0]   pos_ff;
   logic [CW-1:0]      count_ff, count_in;
   logic [AW-1:0]      ptr_ff;
   logic               dir_up_ff;
   logic               wr_pend_ff;
   logic [AW-1:0]      wr_addr_ff;
   logic [VALUE_W-1:0] rdata_ff;
   logic               status_ff;
   logic [VALUE_W-1:0] rdval_ff;
   logic [LEN_W-1:0]   len_ff;

   logic [CMPW-1:0]    cnt_x, pos_x, last_x;
   logic               wr_en, rd_en;
   logic [AW-1:0]      wr_addr, rd_addr;
   logic [VALUE_W-1:0] wr_data;

   assign cnt_x  = CMPW'(count_ff);
   assign pos_x  = CMPW'(pos_ff);
   assign last_x = CMPW'(count_ff - CW'(1));

   assign stat.act        = act_ff;
   assign stat.full       = (count_ff == CW'(CAPACITY));
   assign stat.empty      = (count_ff == '0);
   assign stat.pos_ok     = (pos_ff != '0) && (pos_x <= cnt_x);
   assign stat.pos_at_end = (pos_x == cnt_x);
   assign stat.ptr_last   = dir_up_ff ? (ptr_ff == '0) : (CMPW'(ptr_ff) == last_x);

   // a pending shift write takes the port before any direct insert write
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = '0;
      wr_data = value_ff;
      if (wr_pend_ff) begin
         wr_en   = 1'b1;
         wr_addr = wr_addr_ff;
         wr_data = rdata_ff;
      end else begin
         case (cmd.wr_kind)
            WR_FRONT: wr_en = 1'b1;
            WR_BACK: begin
               wr_en   = 1'b1;
               wr_addr = AW'(count_ff);
            end
            default: wr_en = 1'b0;
         endcase
      end
   end

   assign rd_en   = cmd.step || cmd.rd_pos;
   assign rd_addr = cmd.step ? ptr_ff : AW'(pos_ff - POS_W'(1));

   always_comb begin
      count_in = count_ff;
      case (cmd.cnt_op)
         CNT_INC: count_in = count_ff + CW'(1);
         CNT_DEC: count_in = count_ff - CW'(1);
         CNT_CLR: count_in = '0;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rdata_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         wr_pend_ff <= 1'b0;
      end else begin
         count_ff   <= count_in;
         wr_pend_ff <= cmd.step;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         act_ff   <= action_type'(req_action);
         value_ff <= req_value;
         pos_ff   <= req_position;
      end
      if (cmd.ptr_load) begin
         dir_up_ff <= (act_ff == ACT_INS_FRONT);
         ptr_ff    <= (act_ff == ACT_INS_FRONT) ? AW'(count_ff - CW'(1)) : AW'(pos_ff);
      end else if (cmd.step) begin
         ptr_ff <= dir_up_ff ? ptr_ff - AW'(1) : ptr_ff + AW'(1);
      end
      if (cmd.step) wr_addr_ff <= dir_up_ff ? ptr_ff + AW'(1) : ptr_ff - AW'(1);
      if (cmd.out_load) begin
         status_ff <= cmd.out_err;
         rdval_ff  <= cmd.out_rd ? rdata_ff : '0;
         len_ff    <= LEN_W'(count_ff);
      end
   end

   assign rsp_status     = status_ff;
   assign rsp_read_value = rdval_ff;
   assign rsp_length     = len_ff;

endmodule

// ----- rtl/core/positional_list_store.sv -----
// Top level of the positional list store: ordered list of signed words.
// Throughput: one request at a time; the walk moves one entry per cycle through the
// single-write, single-read entry memory.
// Reset: synchronous, clears the length and the handshake state; memory is not cleared.
module positional_list_store #(
   parameter int unsigned CAPACITY = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,  // action[2:0], value[34:3], position[50:35], zero pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata   // status[0], read_value[32:1], length[41:33], zero pad
);
   import pls_pkg::*;

   cmd_type            cmd;
   stat_type           stat;
   logic               rsp_status;
   logic [VALUE_W-1:0] rsp_read_value;
   logic [LEN_W-1:0]   rsp_length;

   // Controller: one request in flight; the result register frees the input side
   // as soon as the result is loaded, even while it waits for the consumer.
   pls_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // Datapath: entry memory, length count, walk pointer and result register.
   pls_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_action     (req_tdata[2:0]),
      .req_value      (req_tdata[34:3]),
      .req_position   (req_tdata[50:35]),
      .rsp_status     (rsp_status),
      .rsp_read_value (rsp_read_value),
      .rsp_length     (rsp_length)
   );

   // Pack the result fields, lowest field first; pad the upper six bits with zeros.
   assign rsp_tdata = {6'd0, rsp_length, rsp_read_value, rsp_status};

endmodule

// ----- rtl/core/pls_checker.sv -----
// Port-level assertions for the positional list store, bound to the top level.
module pls_checker #(
   parameter int unsigned CAPACITY = 256
) (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [55:0] req_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata
);

   // a stalled result holds its contents
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // an error never carries a read value
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> rsp_tdata[32:1] == 32'd0)
      else $error("error result with non-zero read value");

   // the reported length never exceeds the capacity
   a_len_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> {23'd0, rsp_tdata[41:33]} <= CAPACITY)
      else $error("length beyond capacity");

   // one request at a time: input closes after each transfer
   a_one_req: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second request taken while busy");

   // no result straight after reset
   a_rst_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind positional_list_store pls_checker #(.CAPACITY(CAPACITY)) u_pls_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ----- bench/pls_scoreboard.sv -----
// Scoreboard for the positional list store: list predictor and result checking.
package pls_bench_pkg;

   import pls_pkg::*;

   localparam logic RSP_OK  = 1'b0;
   localparam logic RSP_ERR = 1'b1;

   // action codes past clear are answered with an error and leave the list unchanged
   localparam logic [ACT_W-1:0] ACT_UNUSED_FIRST = ACT_W'(int'(ACT_CLEAR) + 1);
   localparam logic [ACT_W-1:0] ACT_UNUSED_LAST  = '1;

   typedef struct packed {
      logic                      status;
      logic signed [VALUE_W-1:0] read_value;
      logic [LEN_W-1:0]          length;
   } list_result_t;

   class list_scoreboard;
      int unsigned               capacity;
      logic signed [VALUE_W-1:0] contents[$];
      list_result_t              due_results[$];
      int unsigned               mismatches;
      int unsigned               per_action[2**ACT_W];
      int unsigned               results_checked;
      int unsigned               full_refusals;
      int unsigned               longest;

      function new(int unsigned cap);
         capacity = cap;
      endfunction

      // update the list copy and queue the result this request must produce
      function void apply_request(logic [ACT_W-1:0] act, logic [VALUE_W-1:0] val,
                                  logic [POS_W-1:0] pos);
         list_result_t res;
         bit           pos_ok;
         res.status     = RSP_ERR;
         res.read_value = '0;
         pos_ok         = (pos >= 1) && (pos <= contents.size());
         per_action[act]++;
         case (act)
            ACT_INS_FRONT, ACT_INS_BACK: begin
               if (contents.size() < capacity) begin
                  if (act == ACT_INS_FRONT) contents.push_front(val);
                  else contents.push_back(val);
                  res.status = RSP_OK;
               end else begin
                  full_refusals++;
               end
            end
            ACT_REMOVE: begin
               if (pos_ok) begin
                  contents.delete(pos - 1);
                  res.status = RSP_OK;
               end
            end
            ACT_READ: begin
               if (pos_ok) begin
                  res.read_value = contents[pos - 1];
                  res.status     = RSP_OK;
               end
            end
            ACT_CLEAR: begin
               contents.delete();
               res.status = RSP_OK;
            end
            default: ;
         endcase
         res.length = LEN_W'(contents.size());
         if (contents.size() > longest) longest = contents.size();
         due_results.push_back(res);
      endfunction

      function void check_result(logic [47:0] tdata);
         list_result_t want;
         list_result_t got;
         got.status     = tdata[0];
         got.read_value = tdata[VALUE_W:1];
         got.length     = tdata[VALUE_W+LEN_W:VALUE_W+1];
         if (due_results.size() == 0) begin
            $error("unexpected result: status %0d read_value %0d length %0d",
                   got.status, got.read_value, got.length);
            mismatches++;
            return;
         end
         want = due_results.pop_front();
         results_checked++;
         if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            mismatches++;
         end
         if (got.read_value !== want.read_value) begin
            $error("read_value: expected %0d, got %0d", want.read_value, got.read_value);
            mismatches++;
         end
         if (got.length !== want.length) begin
            $error("length: expected %0d, got %0d", want.length, got.length);
            mismatches++;
         end
      endfunction
   endclass

endpackage

// ----- bench/tb_positional_list_store.sv -----
// Top-level bench for the positional list store: directed, fill and random traffic.
module tb_positional_list_store;

   timeunit 1ns;
   timeprecision 1ps;

   import pls_pkg::*;
   import pls_bench_pkg::*;

   localparam int unsigned CAPACITY          = 256;
   localparam int unsigned RANDOM_PER_PHASE  = 110;
   // the slowest request is a front insert into a list of CAPACITY-1 entries
   localparam int unsigned WATCHDOG_LIMIT    = 4000;
   localparam int unsigned DRAIN_CYCLES      = 300;
   localparam logic [VALUE_W-1:0] VALUE_MIN  = 32'h8000_0000;
   localparam logic [VALUE_W-1:0] VALUE_MAX  = 32'h7FFF_FFFF;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [55:0] req_tdata;   // action[2:0], value[34:3], position[50:35], zero pad
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;   // status[0], read_value[32:1], length[41:33], zero pad

   int unsigned    send_idle_pct  = 0;
   int unsigned    recv_stall_pct = 0;
   int unsigned    quiet_cycles   = 0;
   list_scoreboard sb;

   positional_list_store #(.CAPACITY(CAPACITY)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Receiver: decide at each falling edge whether to stall the next cycle.
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Check every result transfer; end the run if nothing moves for too long.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("Watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Present one request at a falling edge, hold it until the block takes it,
   // then note it with the scoreboard. Idle gaps go in front of the request
   // so valid is never dropped and raised within the same step.
   task automatic send_req(input logic [ACT_W-1:0] act, input logic [VALUE_W-1:0] val,
                           input logic [POS_W-1:0] pos);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tdata  <= 56'({pos, val, act});
      req_tvalid <= 1'b1;
      do @(posedge clock); while (req_tready !== 1'b1);
      sb.apply_request(act, val, pos);
   endtask

   // Edge cases on a short list: empty-list errors, extreme values, positions
   // at zero, at the ends and beyond, and the unused action codes.
   task automatic run_directed;
      send_req(ACT_READ,      '0,        1);
      send_req(ACT_REMOVE,    '0,        1);
      send_req(ACT_CLEAR,     '0,        0);
      send_req(ACT_INS_FRONT, VALUE_MAX, 0);
      send_req(ACT_INS_BACK,  VALUE_MIN, 0);
      send_req(ACT_INS_FRONT, '0,        '1);
      send_req(ACT_INS_BACK,  '1,        '1);
      send_req(ACT_INS_FRONT, 32'h5A5A_A5A5, 2);
      send_req(ACT_READ,      '0,        0);
      send_req(ACT_READ,      '1,        1);
      send_req(ACT_READ,      '0,        5);
      send_req(ACT_READ,      '0,        6);
      send_req(ACT_READ,      '0,        '1);
      send_req(ACT_REMOVE,    '0,        0);
      send_req(ACT_REMOVE,    '0,        6);
      send_req(ACT_REMOVE,    '0,        5);
      send_req(ACT_REMOVE,    '0,        2);
      send_req(ACT_REMOVE,    '0,        1);
      send_req(ACT_READ,      '0,        2);
      for (int c = ACT_UNUSED_FIRST; c <= ACT_UNUSED_LAST; c++) begin
         send_req(ACT_W'(c), '1, 1);
      end
      send_req(ACT_CLEAR,     '1,        '1);
      send_req(ACT_READ,      '0,        1);
   endtask

   // Fill the list to capacity, push against the full limit, then work both
   // ends: the longest walks and shifts the block can make.
   task automatic fill_to_capacity;
      send_req(ACT_CLEAR, $urandom(), POS_W'($urandom()));
      while (sb.contents.size() < CAPACITY) begin
         send_req($urandom_range(1) ? ACT_INS_BACK : ACT_INS_FRONT, $urandom(),
                  POS_W'($urandom()));
      end
      send_req(ACT_INS_FRONT, $urandom(), 0);
      send_req(ACT_INS_BACK,  $urandom(), 0);
      send_req(ACT_READ,      '0, POS_W'(CAPACITY));
      send_req(ACT_READ,      '0, POS_W'(CAPACITY + 1));
      send_req(ACT_REMOVE,    '0, POS_W'(CAPACITY + 1));
      send_req(ACT_REMOVE,    '0, POS_W'(CAPACITY));
      send_req(ACT_INS_FRONT, $urandom(), 0);
      send_req(ACT_INS_BACK,  $urandom(), 0);
      send_req(ACT_REMOVE,    '0, 1);
      send_req(ACT_READ,      '0, 1);
      send_req(ACT_REMOVE,    '0, POS_W'(CAPACITY / 2));
      send_req(ACT_READ,      '0, POS_W'(CAPACITY / 2));
   endtask

   // One random request, weighted towards inserts and reads so the list keeps
   // some depth; positions are mostly valid with a tail of bad ones.
   task automatic send_random;
      logic [ACT_W-1:0]   act;
      logic [VALUE_W-1:0] val;
      logic [POS_W-1:0]   pos;
      int unsigned        len;
      int unsigned        pick;
      len  = sb.contents.size();
      pick = $urandom_range(99);
      if (pick < 24)      act = ACT_INS_FRONT;
      else if (pick < 46) act = ACT_INS_BACK;
      else if (pick < 65) act = ACT_REMOVE;
      else if (pick < 95) act = ACT_READ;
      else if (pick < 97) act = ACT_CLEAR;
      else act = ACT_W'($urandom_range(ACT_UNUSED_LAST, ACT_UNUSED_FIRST));
      case ($urandom_range(9))
         0:       val = VALUE_MIN;
         1:       val = VALUE_MAX;
         2:       val = $urandom_range(1) ? '1 : '0;
         default: val = $urandom();
      endcase
      if (len > 0 && $urandom_range(9) < 8) begin
         pos = POS_W'($urandom_range(len, 1));
      end else begin
         case ($urandom_range(3))
            0:       pos = '0;
            1:       pos = POS_W'(len + 1);
            2:       pos = '1;
            default: pos = POS_W'($urandom());
         endcase
      end
      send_req(act, val, pos);
   endtask

   initial begin
      sb         = new(CAPACITY);
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Phases: no idling, sender gaps, receiver stalls, light idling on both.
      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct  = (phase == 1) ? 45 : (phase == 3) ? 9 : 0;
         recv_stall_pct = (phase == 2) ? 45 : (phase == 3) ? 9 : 0;
         if (phase == 0) run_directed();
         if (phase == 1) fill_to_capacity();
         repeat (RANDOM_PER_PHASE) send_random();
      end
      @(negedge clock);
      req_tvalid <= 1'b0;

      // Drain outstanding results, then allow time for any stray transfer.
      while (sb.due_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d front inserts, %0d back inserts, %0d removes, %0d reads, %0d clears",
               sb.per_action[ACT_INS_FRONT], sb.per_action[ACT_INS_BACK],
               sb.per_action[ACT_REMOVE], sb.per_action[ACT_READ], sb.per_action[ACT_CLEAR]);
      $display("Checked %0d results; list reached %0d of %0d entries, %0d inserts refused when full",
               sb.results_checked, sb.longest, CAPACITY, sb.full_refusals);
      if (sb.mismatches == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
